// ----- sv/nbtp_pkg.sv -----
// Shared types, codes and constants of the nested block time profiler.
package nbtp_pkg;

  localparam int IDX_W   = 8;
  localparam int TICK_W  = 64;
  localparam int LEVEL_W = 6;
  localparam int CFG_W   = 9;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  localparam int DEF_MAX_BLOCKS  = 256;
  localparam int DEF_STACK_DEPTH = 32;

  // register index taken from paddr[2]
  localparam logic REG_ACTIVE_BLOCKS = 1'b0;

  typedef enum logic [1:0] {
    K_ENTER = 2'd0,
    K_LEAVE = 2'd1,
    K_READ  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_BADINDEX = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [IDX_W-1:0]  block_index;
    logic [TICK_W-1:0] event_tick;
    logic [TICK_W-1:0] resume_tick;
  } item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [TICK_W-1:0]  exclusive_total;
    logic [TICK_W-1:0]  inclusive_total;
    logic [LEVEL_W-1:0] stack_level;
  } result_t;

  typedef struct packed {
    logic [IDX_W-1:0]  block;
    logic [TICK_W-1:0] outer_start;
    logic [TICK_W-1:0] inner_start;
    logic [TICK_W-1:0] overhead;
  } frame_t;

  typedef struct packed {
    logic [TICK_W-1:0] excl;
    logic [TICK_W-1:0] incl;
  } totals_t;

endpackage

// ----- sv/nbtp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module nbtp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- sv/nbtp_blk_table.sv -----
// Per-block table: nesting count and time totals, cleared at reset by valid bits.
module nbtp_blk_table #(
  parameter int DEPTH  = 256,
  parameter int NEST_W = 6,
  parameter int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  output logic [NEST_W-1:0]     rd_nest,
  output nbtp_pkg::totals_t     rd_tot,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  logic [NEST_W-1:0]     wr_nest,
  input  nbtp_pkg::totals_t     wr_tot
);
  import nbtp_pkg::*;

  localparam int WIDTH = NEST_W + $bits(totals_t);

  logic [DEPTH-1:0] valid;
  logic             valid_q;
  logic             fwd_hit;
  logic [WIDTH-1:0] fwd_data;
  logic [WIDTH-1:0] ram_rd;
  logic [WIDTH-1:0] word;

  nbtp_ram #(.WIDTH(WIDTH), .DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data ({wr_nest, wr_tot}),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (ram_rd)
  );

  // RAM reads old data on a same-address write; capture the new word instead
  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      valid_q <= 1'b0;
      fwd_hit <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        valid_q <= valid[rd_addr];
        fwd_hit <= wr_en && (wr_addr == rd_addr);
      end
    end
    if (rd_en) begin
      fwd_data <= {wr_nest, wr_tot};
    end
  end

  always_comb begin
    if (fwd_hit) begin
      word = fwd_data;
    end else if (valid_q) begin
      word = ram_rd;
    end else begin
      word = '0;
    end
  end

  assign rd_nest = word[WIDTH-1 -: NEST_W];
  assign rd_tot  = word[$bits(totals_t)-1:0];

  a_valid_set: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> valid[$past(wr_addr)])
    else $error("written entry not marked valid");

endmodule

// ----- sv/nested_block_time_profiler_unit.sv -----
// Nested block time profiler: call stack, per-block totals and APB config.
//
// Usage: items (enter, leave, read) arrive on item_valid/item_ready and
// each gives exactly one result on result_valid/result_ready, in order.
// The top stack frame lives in registers; lower frames sit in a stack RAM.
// Per-block nesting counts and totals sit in a block RAM, read-modify-write.
// Path from acceptance to the result being registered:
//   rejected item or unused kind: finished in the idle state
//   read, leave: finished in S_A; enter on an empty stack: finished in S_B
//   enter on a non-empty stack: S_A then S_B (two RMWs through the block RAM's one read port)
// A new item is accepted in the cycle after the previous result registers,
// so the block takes no new item before the last one's result is registered.
// The result waits in an output register; if it is still unread when the
// next result is ready, that one parks in a hold register and item_ready
// stays low until the output register is taken.
// Reset (rst, synchronous) empties the stack, clears all block totals at once through
// valid bits and sets active_blocks to 0. active_blocks is written over APB at paddr 0;
// the user must write it only while no item is in flight; the block does not enforce this.
module nested_block_time_profiler_unit #(
  parameter int MAX_BLOCKS  = nbtp_pkg::DEF_MAX_BLOCKS,
  parameter int STACK_DEPTH = nbtp_pkg::DEF_STACK_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  nbtp_pkg::item_t               item,
  output logic                          result_valid,
  input  logic                          result_ready,
  output nbtp_pkg::result_t             result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [nbtp_pkg::APB_AW-1:0]   paddr,
  input  logic [nbtp_pkg::APB_DW-1:0]   pwdata,
  output logic [nbtp_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import nbtp_pkg::*;

  localparam int IDX_SPAN  = 1 << IDX_W;
  localparam int BLK_DEPTH = (MAX_BLOCKS < IDX_SPAN) ? MAX_BLOCKS : IDX_SPAN;
  localparam int BLK_AW    = (BLK_DEPTH > 1) ? $clog2(BLK_DEPTH) : 1;
  localparam int SP_W      = $clog2(STACK_DEPTH + 1);
  localparam int SA_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int NEST_W    = SP_W;

  typedef enum logic [1:0] {S_IDLE, S_A, S_B, S_HOLD} state_t;

  state_t            st;
  logic [1:0]        op;
  logic [IDX_W-1:0]  op_blk;
  logic [TICK_W-1:0] excl_d;
  logic [TICK_W-1:0] span_d;
  logic [TICK_W-1:0] child;
  logic [TICK_W-1:0] rs_q;
  logic [SP_W-1:0]   sp;
  frame_t            top;
  logic [CFG_W-1:0]  active_blocks;
  result_t           res;

  // memory ports
  logic              blk_rd_en;
  logic [BLK_AW-1:0] blk_rd_addr;
  logic [NEST_W-1:0] blk_rd_nest;
  totals_t           blk_rd_tot;
  logic              blk_wr_en;
  logic [BLK_AW-1:0] blk_wr_addr;
  logic [NEST_W-1:0] blk_wr_nest;
  totals_t           blk_wr_tot;
  logic              stk_rd_en;
  logic [SA_W-1:0]   stk_rd_addr;
  frame_t            stk_rd;
  logic              stk_wr_en;
  logic [SA_W-1:0]   stk_wr_addr;

  logic              fin;
  result_t           fin_res;
  logic              idx_ok;
  logic              out_free;
  logic              cfg_we;
  logic [NEST_W-1:0] nest_dec;

  assign item_ready = (st == S_IDLE);
  assign out_free   = !result_valid || result_ready;
  assign pready     = 1'b1;
  assign cfg_we     = psel && penable && pwrite;
  assign prdata     = (paddr[2] == REG_ACTIVE_BLOCKS) ? APB_DW'(active_blocks) : '0;

  assign idx_ok = ({1'b0, item.block_index} < active_blocks) &&
                  (32'(item.block_index) < MAX_BLOCKS);

  nbtp_ram #(.WIDTH($bits(frame_t)), .DEPTH(STACK_DEPTH), .AW(SA_W)) u_stack (
    .clk     (clk),
    .wr_en   (stk_wr_en),
    .wr_addr (stk_wr_addr),
    .wr_data (top),
    .rd_en   (stk_rd_en),
    .rd_addr (stk_rd_addr),
    .rd_data (stk_rd)
  );

  nbtp_blk_table #(.DEPTH(BLK_DEPTH), .NEST_W(NEST_W), .AW(BLK_AW)) u_blk (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (blk_rd_en),
    .rd_addr (blk_rd_addr),
    .rd_nest (blk_rd_nest),
    .rd_tot  (blk_rd_tot),
    .wr_en   (blk_wr_en),
    .wr_addr (blk_wr_addr),
    .wr_nest (blk_wr_nest),
    .wr_tot  (blk_wr_tot)
  );

  always_comb begin
    blk_rd_en   = 1'b0;
    blk_rd_addr = '0;
    blk_wr_en   = 1'b0;
    blk_wr_addr = '0;
    blk_wr_nest = blk_rd_nest;
    blk_wr_tot  = blk_rd_tot;
    stk_rd_en   = 1'b0;
    stk_rd_addr = '0;
    stk_wr_en   = 1'b0;
    stk_wr_addr = '0;
    fin         = 1'b0;
    fin_res     = '0;
    fin_res.status      = ST_OK;
    fin_res.stack_level = LEVEL_W'(sp);
    nest_dec    = (blk_rd_nest != '0) ? NEST_W'(blk_rd_nest - 1'b1) : '0;
    case (st)
      S_IDLE: begin
        if (item_valid) begin
          case (item.kind)
            K_ENTER: begin
              if (!idx_ok) begin
                fin            = 1'b1;
                fin_res.status = ST_BADINDEX;
              end else if (sp >= SP_W'(STACK_DEPTH)) begin
                fin            = 1'b1;
                fin_res.status = ST_OVERFLOW;
              end else begin
                blk_rd_en = 1'b1;
                if (sp != '0) begin
                  // charge the running top, push it below the new frame
                  blk_rd_addr = top.block[BLK_AW-1:0];
                  stk_wr_en   = 1'b1;
                  stk_wr_addr = SA_W'(sp - 1'b1);
                end else begin
                  blk_rd_addr = item.block_index[BLK_AW-1:0];
                end
              end
            end
            K_LEAVE: begin
              if (sp == '0) begin
                fin            = 1'b1;
                fin_res.status = ST_EMPTY;
              end else begin
                blk_rd_en   = 1'b1;
                blk_rd_addr = top.block[BLK_AW-1:0];
                if (sp >= SP_W'(2)) begin
                  stk_rd_en   = 1'b1;
                  stk_rd_addr = SA_W'(sp - SP_W'(2));
                end
              end
            end
            K_READ: begin
              if (!idx_ok) begin
                fin            = 1'b1;
                fin_res.status = ST_BADINDEX;
              end else begin
                blk_rd_en   = 1'b1;
                blk_rd_addr = item.block_index[BLK_AW-1:0];
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      S_A: begin
        case (op)
          K_ENTER: begin
            blk_wr_en       = 1'b1;
            blk_wr_addr     = op_blk[BLK_AW-1:0];
            blk_wr_tot.excl = blk_rd_tot.excl + excl_d;
            blk_rd_en       = 1'b1;
            blk_rd_addr     = top.block[BLK_AW-1:0];
          end
          K_LEAVE: begin
            blk_wr_en       = 1'b1;
            blk_wr_addr     = op_blk[BLK_AW-1:0];
            blk_wr_nest     = nest_dec;
            blk_wr_tot.excl = blk_rd_tot.excl + excl_d;
            // inclusive time only when the outermost instance exits
            blk_wr_tot.incl = blk_rd_tot.incl + ((nest_dec == '0) ? span_d : '0);
            fin             = 1'b1;
          end
          K_READ: begin
            fin                     = 1'b1;
            fin_res.exclusive_total = blk_rd_tot.excl;
            fin_res.inclusive_total = blk_rd_tot.incl;
          end
          default: ;
        endcase
      end
      S_B: begin
        blk_wr_en   = 1'b1;
        blk_wr_addr = top.block[BLK_AW-1:0];
        blk_wr_nest = NEST_W'(blk_rd_nest + 1'b1);
        fin         = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st            <= S_IDLE;
      sp            <= '0;
      result_valid  <= 1'b0;
      active_blocks <= '0;
    end else begin
      if (cfg_we && paddr[2] == REG_ACTIVE_BLOCKS) begin
        active_blocks <= pwdata[CFG_W-1:0];
      end
      if (fin && out_free) begin
        result       <= fin_res;
        result_valid <= 1'b1;
        st           <= S_IDLE;
      end else if (fin) begin
        res <= fin_res;
        st  <= S_HOLD;
      end else if (st == S_HOLD && out_free) begin
        result       <= res;
        result_valid <= 1'b1;
        st           <= S_IDLE;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      case (st)
        S_IDLE: begin
          if (item_valid && !fin) begin
            op     <= item.kind;
            rs_q   <= item.resume_tick;
            excl_d <= item.event_tick - top.inner_start;
            case (item.kind)
              K_ENTER: begin
                op_blk <= top.block;
                top    <= '{block:       item.block_index,
                            outer_start: item.event_tick,
                            inner_start: item.resume_tick,
                            overhead:    item.resume_tick - item.event_tick};
                sp     <= sp + 1'b1;
                st     <= (sp != '0) ? S_A : S_B;
              end
              K_LEAVE: begin
                op_blk <= top.block;
                span_d <= item.event_tick - top.outer_start - top.overhead;
                child  <= top.overhead + (item.resume_tick - item.event_tick);
                sp     <= sp - 1'b1;
                st     <= S_A;
              end
              K_READ: begin
                op_blk <= item.block_index;
                st     <= S_A;
              end
              default: ;
            endcase
          end
        end
        S_A: begin
          if (op == K_ENTER) begin
            st <= S_B;
          end
          if (op == K_LEAVE && sp != '0) begin
            // enclosing frame resumes and inherits the child's overhead
            top <= '{block:       stk_rd.block,
                      outer_start: stk_rd.outer_start,
                      inner_start: rs_q,
                      overhead:    stk_rd.overhead + child};
          end
        end
        default: ;
      endcase
    end
  end

  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= SP_W'(STACK_DEPTH))
    else $error("stack pointer beyond depth");

  a_sp_only_on_accept: assert property (@(posedge clk) disable iff (rst)
    !(item_valid && item_ready) |=> $stable(sp))
    else $error("stack pointer moved without a transaction");

  a_err_no_totals: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status != ST_OK) |->
      (result.exclusive_total == '0 && result.inclusive_total == '0))
    else $error("totals reported with an error status");

  a_hold_busy: assert property (@(posedge clk) disable iff (rst)
    (st == S_HOLD) |-> result_valid)
    else $error("parked result while output register empty");

endmodule
